// ----- hdl/video_frame_keyframe_gate_macros.svh -----
// Assertion macros used by the keyframe gate top level.
`ifndef VIDEO_FRAME_KEYFRAME_GATE_MACROS_SVH
`define VIDEO_FRAME_KEYFRAME_GATE_MACROS_SVH

// The antecedent implies the consequent in the same cycle.
`define KFG_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define KFG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/kfg_pkg.sv -----
// Types and constants shared by the keyframe gate modules.
package kfg_pkg;

  typedef enum logic [1:0] {
    FMT_MJPEG = 2'd0,
    FMT_H264  = 2'd1,
    FMT_VP8   = 2'd2,
    FMT_OTHER = 2'd3
  } fmt_t;

  typedef enum logic [2:0] {
    ACT_DECODE    = 3'd0,
    ACT_DROP      = 3'd1,
    ACT_OTHER_FMT = 3'd2,
    ACT_LEN_ERR   = 3'd3,
    ACT_UNKNOWN   = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    PH_SEEK   = 2'd0,
    PH_HEADER = 2'd1,
    PH_DONE   = 2'd2
  } scan_phase_t;

  localparam logic [4:0] NAL_UNSPEC = 5'd0;
  localparam logic [4:0] NAL_IDR    = 5'd5;
  localparam logic [4:0] NAL_SPS    = 5'd7;
  localparam logic [4:0] NAL_PPS    = 5'd8;
  localparam logic [4:0] NAL_AUD    = 5'd9;

  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [7:0] BYTE_ONE  = 8'h01;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        last_byte;
    fmt_t        frame_format;
    logic [15:0] frame_width;
    logic [15:0] frame_height;
    logic [31:0] frame_sequence;
    logic [31:0] declared_bytes;
  } in_item_t;

  typedef struct packed {
    logic        verdict;
    logic [31:0] byte_count;
  } scan_res_t;

  typedef struct packed {
    action_t action;
    logic    gap;
    logic    key;
    logic    waiting;
  } result_t;

endpackage

// ----- hdl/video_frame_keyframe_gate.sv -----
// Top level of the video frame keyframe gate: input register, scanner, verdict, result register.
// Takes one payload byte per clock, with header fields sampled on the byte flagged as first,
// except while a last byte waits on a stalled result register. Each byte is registered in the
// input register and is then folded into the frame state; the per-byte start code scan and
// byte count are combinational, which sets the rate of one byte per clock. On the last byte
// of a frame one verdict is written to the result register as the byte leaves the input
// register. The input side keeps accepting while a verdict waits, and stalls only when a
// last byte meets a full, stalled result register. No clearing pass follows reset.
`include "video_frame_keyframe_gate_macros.svh"

module video_frame_keyframe_gate (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [7:0] data_byte, [23:8] frame_width, [39:24] frame_height,
  // [71:40] frame_sequence, [103:72] declared_bytes
  input  logic [103:0] s_axis_tdata,
  // [0] first_byte, [2:1] frame_format
  input  logic [2:0]   s_axis_tuser,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [2:0] frame_action, [3] sequence_gap, [4] keyframe_seen, [5] still_waiting, [7:6] zero
  output logic [7:0]   m_axis_tdata
);

  logic               in_valid;
  kfg_pkg::in_item_t  in_item;
  logic               out_free;
  logic               advance;
  kfg_pkg::scan_res_t scan_res;
  kfg_pkg::result_t   result;
  kfg_pkg::result_t   out_data;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign advance       = in_valid && (!in_item.last_byte || out_free);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item.data_byte      <= s_axis_tdata[7:0];
      in_item.frame_width    <= s_axis_tdata[23:8];
      in_item.frame_height   <= s_axis_tdata[39:24];
      in_item.frame_sequence <= s_axis_tdata[71:40];
      in_item.declared_bytes <= s_axis_tdata[103:72];
      in_item.first_byte     <= s_axis_tuser[0];
      in_item.frame_format   <= kfg_pkg::fmt_t'(s_axis_tuser[2:1]);
      in_item.last_byte      <= s_axis_tlast;
    end
  end

  kfg_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .data_byte  (in_item.data_byte),
    .first_byte (in_item.first_byte),
    .last_byte  (in_item.last_byte),
    .res        (scan_res)
  );

  kfg_gate u_gate (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (in_item),
    .scan (scan_res),
    .res  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance && in_item.last_byte) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_item.last_byte) begin
      out_data <= result;
    end
  end

  assign m_axis_tdata = {2'b00, out_data.waiting, out_data.key, out_data.gap,
                         out_data.action};

  // A last byte must never overwrite a verdict that is still waiting.
  `KFG_ASSERT_SAME(a_no_overwrite,
                   m_axis_tvalid && !m_axis_tready && in_valid && in_item.last_byte,
                   !advance, "last byte advanced over a stalled verdict")
  // An empty input register always takes a new transaction.
  `KFG_ASSERT_SAME(a_ready_when_empty, !in_valid, s_axis_tready,
                   "input register empty but not ready")
  // Every completed frame shows up as a verdict in the next cycle.
  `KFG_ASSERT_NEXT(a_verdict_follows, advance && in_item.last_byte, m_axis_tvalid,
                   "frame end gave no verdict")
  // Only frames that took the H.264 path can carry a keyframe mark.
  `KFG_ASSERT_SAME(a_key_only_h264, m_axis_tvalid && out_data.key,
                   out_data.action == kfg_pkg::ACT_DECODE ||
                   out_data.action == kfg_pkg::ACT_DROP,
                   "keyframe mark on a non H.264 verdict")
  // A dropped frame leaves the gate waiting for a keyframe.
  `KFG_ASSERT_SAME(a_drop_waits, m_axis_tvalid && out_data.action == kfg_pkg::ACT_DROP,
                   out_data.waiting, "dropped frame without wait flag")

endmodule

// ----- hdl/kfg_scan.sv -----
// Annex B start code scanner and byte counter for the frame in progress.
module kfg_scan (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          data_byte,
  input  logic                first_byte,
  input  logic                last_byte,
  output kfg_pkg::scan_res_t  res
);

  logic [31:0]          byte_counter, byte_counter_cur, byte_counter_next;
  logic [1:0]           zero_run, zero_run_cur, zero_run_next;
  kfg_pkg::scan_phase_t scan_phase, scan_phase_cur, scan_phase_next;
  logic                 seen_sps, seen_sps_cur, seen_sps_next;
  logic                 seen_pps, seen_pps_cur, seen_pps_next;
  logic                 scan_verdict, scan_verdict_cur, scan_verdict_next;
  logic [4:0]           nal_type;

  assign nal_type = data_byte[4:0];

  always_comb begin
    // A first byte starts the scan afresh before this byte is looked at.
    byte_counter_cur = first_byte ? 32'd0 : byte_counter;
    zero_run_cur     = first_byte ? 2'd0 : zero_run;
    scan_phase_cur   = first_byte ? kfg_pkg::PH_SEEK : scan_phase;
    seen_sps_cur     = first_byte ? 1'b0 : seen_sps;
    seen_pps_cur     = first_byte ? 1'b0 : seen_pps;
    scan_verdict_cur = first_byte ? 1'b0 : scan_verdict;

    byte_counter_next = (byte_counter_cur == '1) ? byte_counter_cur
                                                 : byte_counter_cur + 32'd1;
    zero_run_next     = zero_run_cur;
    scan_phase_next   = scan_phase_cur;
    seen_sps_next     = seen_sps_cur;
    seen_pps_next     = seen_pps_cur;
    scan_verdict_next = scan_verdict_cur;

    unique case (scan_phase_cur)
      kfg_pkg::PH_HEADER: begin
        scan_phase_next = kfg_pkg::PH_SEEK;
        zero_run_next   = 2'd0;
        priority if (nal_type == kfg_pkg::NAL_IDR || nal_type == kfg_pkg::NAL_AUD) begin
          scan_verdict_next = 1'b1;
          scan_phase_next   = kfg_pkg::PH_DONE;
        end else if (nal_type == kfg_pkg::NAL_SPS) begin
          seen_sps_next = 1'b1;
        end else if (nal_type == kfg_pkg::NAL_PPS) begin
          if (seen_sps_cur) begin
            seen_pps_next = 1'b1;
          end else begin
            scan_verdict_next = 1'b0;
            scan_phase_next   = kfg_pkg::PH_DONE;
          end
        end else if (nal_type != kfg_pkg::NAL_UNSPEC) begin
          scan_verdict_next = seen_sps_cur && seen_pps_cur;
          scan_phase_next   = kfg_pkg::PH_DONE;
        end else begin
          // An unspecified NAL type is skipped and the scan goes on seeking.
        end
      end
      kfg_pkg::PH_SEEK: begin
        priority if (data_byte == kfg_pkg::BYTE_ZERO) begin
          if (zero_run_cur < 2'd2) begin
            zero_run_next = zero_run_cur + 2'd1;
          end
        end else if (data_byte == kfg_pkg::BYTE_ONE && zero_run_cur >= 2'd2) begin
          scan_phase_next = kfg_pkg::PH_HEADER;
          zero_run_next   = 2'd0;
        end else begin
          zero_run_next = 2'd0;
        end
      end
      default: begin
      end
    endcase

    // An unfinished scan falls back to whether both parameter sets turned up.
    res.verdict    = (scan_phase_next == kfg_pkg::PH_DONE) ? scan_verdict_next
                                                           : (seen_sps_next && seen_pps_next);
    res.byte_count = byte_counter_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && last_byte)) begin
      byte_counter <= '0;
      zero_run     <= '0;
      scan_phase   <= kfg_pkg::PH_SEEK;
      seen_sps     <= 1'b0;
      seen_pps     <= 1'b0;
      scan_verdict <= 1'b0;
    end else if (step) begin
      byte_counter <= byte_counter_next;
      zero_run     <= zero_run_next;
      scan_phase   <= scan_phase_next;
      seen_sps     <= seen_sps_next;
      seen_pps     <= seen_pps_next;
      scan_verdict <= scan_verdict_next;
    end
  end

endmodule

// ----- hdl/kfg_gate.sv -----
// Header latch, stream state and the per-frame verdict.
module kfg_gate (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  kfg_pkg::in_item_t   item,
  input  kfg_pkg::scan_res_t  scan,
  output kfg_pkg::result_t    res
);

  logic [31:0]   prev_sequence, prev_sequence_next;
  logic [15:0]   stream_width, stream_width_next;
  logic [15:0]   stream_height, stream_height_next;
  logic          decoder_ready, decoder_ready_next;
  logic          wait_keyframe, wait_keyframe_next;
  kfg_pkg::fmt_t hdr_format, fmt_cur;
  logic [31:0]   hdr_sequence, seq_cur;
  logic [31:0]   hdr_length, len_cur;
  logic [15:0]   hdr_width, width_cur;
  logic [15:0]   hdr_height, height_cur;
  logic          gap;

  always_comb begin
    fmt_cur    = item.first_byte ? item.frame_format   : hdr_format;
    seq_cur    = item.first_byte ? item.frame_sequence : hdr_sequence;
    len_cur    = item.first_byte ? item.declared_bytes : hdr_length;
    width_cur  = item.first_byte ? item.frame_width    : hdr_width;
    height_cur = item.first_byte ? item.frame_height   : hdr_height;

    gap = (prev_sequence + 32'd1) != seq_cur;

    prev_sequence_next = seq_cur;
    stream_width_next  = stream_width;
    stream_height_next = stream_height;
    decoder_ready_next = decoder_ready;
    wait_keyframe_next = wait_keyframe;
    res.action         = kfg_pkg::ACT_DECODE;
    res.key            = 1'b0;

    if (scan.byte_count == 32'd0 || scan.byte_count != len_cur) begin
      res.action = kfg_pkg::ACT_LEN_ERR;
    end else begin
      unique case (fmt_cur)
        kfg_pkg::FMT_MJPEG: begin
          decoder_ready_next = 1'b0;
          res.action         = kfg_pkg::ACT_OTHER_FMT;
        end
        kfg_pkg::FMT_VP8: begin
          wait_keyframe_next = wait_keyframe || gap;
          decoder_ready_next = 1'b0;
          res.action         = kfg_pkg::ACT_OTHER_FMT;
        end
        kfg_pkg::FMT_H264: begin
          wait_keyframe_next = wait_keyframe || gap;
          if (stream_width != width_cur || stream_height != height_cur) begin
            decoder_ready_next = 1'b0;
            stream_width_next  = width_cur;
            stream_height_next = height_cur;
          end
          // A torn-down decoder is rebuilt and has to see a keyframe first.
          if (!decoder_ready_next) begin
            decoder_ready_next = 1'b1;
            wait_keyframe_next = 1'b1;
          end
          res.key = scan.verdict;
          if (wait_keyframe_next) begin
            if (scan.verdict) begin
              wait_keyframe_next = 1'b0;
            end else begin
              res.action = kfg_pkg::ACT_DROP;
            end
          end
        end
        default: begin
          res.action = kfg_pkg::ACT_UNKNOWN;
        end
      endcase
    end

    res.gap     = gap;
    res.waiting = wait_keyframe_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_sequence <= '1;
      stream_width  <= '0;
      stream_height <= '0;
      decoder_ready <= 1'b0;
      wait_keyframe <= 1'b1;
      hdr_format    <= kfg_pkg::FMT_MJPEG;
      hdr_sequence  <= '0;
      hdr_length    <= '0;
      hdr_width     <= '0;
      hdr_height    <= '0;
    end else if (step) begin
      if (item.first_byte) begin
        hdr_format   <= item.frame_format;
        hdr_sequence <= item.frame_sequence;
        hdr_length   <= item.declared_bytes;
        hdr_width    <= item.frame_width;
        hdr_height   <= item.frame_height;
      end
      if (item.last_byte) begin
        prev_sequence <= prev_sequence_next;
        stream_width  <= stream_width_next;
        stream_height <= stream_height_next;
        decoder_ready <= decoder_ready_next;
        wait_keyframe <= wait_keyframe_next;
      end
    end
  end

endmodule

// ----- tb/sv/tb_video_frame_keyframe_gate.sv -----
// Self-checking testbench for the video frame keyframe gate, with a built-in predictor.
module tb_video_frame_keyframe_gate;

  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_BYTES = 1200;

  // Receiver stall styles.
  localparam int RX_ALWAYS  = 0;
  localparam int RX_RANDOM  = 1;
  localparam int RX_SPARSE  = 2;
  localparam int RX_PATTERN = 3;

  // Sender pacing styles.
  localparam int TX_DENSE  = 0;
  localparam int TX_BURSTY = 1;

  // Coded slice of an ordinary picture.
  localparam logic [4:0] NAL_SLICE = 5'd1;

  logic         clk     = 1'b0;
  logic         rst     = 1'b1;
  logic         s_valid = 1'b0;
  wire          s_ready;
  // [7:0] data_byte, [23:8] frame_width, [39:24] frame_height,
  // [71:40] frame_sequence, [103:72] declared_bytes
  logic [103:0] s_data  = '0;
  // [0] first_byte, [2:1] frame_format
  logic [2:0]   s_user  = '0;
  logic         s_last  = 1'b0;
  wire          m_valid;
  logic         m_ready = 1'b0;
  // [2:0] frame_action, [3] sequence_gap, [4] keyframe_seen, [5] still_waiting, [7:6] zero
  wire  [7:0]   m_data;

  video_frame_keyframe_gate i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .s_axis_tlast  (s_last),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Run timed out");
    $display("Verification failed");
    $finish;
  end

  // Predictor state.
  logic [31:0]          prev_seq;
  logic [15:0]          strm_w;
  logic [15:0]          strm_h;
  logic                 dec_ready;
  logic                 wait_kf;
  kfg_pkg::fmt_t        hdr_fmt;
  logic [15:0]          hdr_w;
  logic [15:0]          hdr_h;
  logic [31:0]          hdr_seq;
  logic [31:0]          hdr_len;
  logic [31:0]          byte_cnt;
  logic [1:0]           zero_run;
  kfg_pkg::scan_phase_t phase;
  logic                 seen_sps;
  logic                 seen_pps;
  logic                 scan_key;

  kfg_pkg::result_t     verdict_q[$];
  kfg_pkg::in_item_t    seen_item;
  int                   err_count = 0;

  // Stimulus state.
  logic [7:0]  frame_bytes[$];
  int          burst_left = 0;
  int          tx_mode    = TX_BURSTY;
  int          rx_mode    = RX_ALWAYS;
  int          bytes_sent = 0;
  logic [31:0] stim_seq   = '0;
  logic [15:0] stim_w     = '0;
  logic [15:0] stim_h     = '0;

  // Receiver state.
  int          hold_reqs = 0;
  int          hold_done = 0;
  int          hold_left = 0;
  int          rx_tick   = 0;
  logic [7:0]  rx_pat    = 8'hb5;

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("MISMATCH at %0t: %s expected %0h got %0h", $time, what, want, got);
    err_count++;
  endtask

  task automatic scan_clear();
    byte_cnt = '0;
    zero_run = '0;
    phase    = kfg_pkg::PH_SEEK;
    seen_sps = 1'b0;
    seen_pps = 1'b0;
    scan_key = 1'b0;
  endtask

  // Folds one accepted byte into the frame state; a last byte yields a verdict.
  task automatic fold_frame_byte(input kfg_pkg::in_item_t it);
    logic [4:0]       nal;
    logic             gap;
    kfg_pkg::result_t r;
    if (it.first_byte) begin
      hdr_fmt = it.frame_format;
      hdr_w   = it.frame_width;
      hdr_h   = it.frame_height;
      hdr_seq = it.frame_sequence;
      hdr_len = it.declared_bytes;
      scan_clear();
    end
    if (byte_cnt != '1) byte_cnt = byte_cnt + 32'd1;
    case (phase)
      kfg_pkg::PH_HEADER: begin
        nal      = it.data_byte[4:0];
        phase    = kfg_pkg::PH_SEEK;
        zero_run = '0;
        if (nal == kfg_pkg::NAL_IDR || nal == kfg_pkg::NAL_AUD) begin
          scan_key = 1'b1;
          phase    = kfg_pkg::PH_DONE;
        end else if (nal == kfg_pkg::NAL_SPS) begin
          seen_sps = 1'b1;
        end else if (nal == kfg_pkg::NAL_PPS) begin
          if (seen_sps) begin
            seen_pps = 1'b1;
          end else begin
            scan_key = 1'b0;
            phase    = kfg_pkg::PH_DONE;
          end
        end else if (nal != kfg_pkg::NAL_UNSPEC) begin
          scan_key = seen_sps && seen_pps;
          phase    = kfg_pkg::PH_DONE;
        end
      end
      kfg_pkg::PH_SEEK: begin
        if (it.data_byte == kfg_pkg::BYTE_ZERO) begin
          if (zero_run < 2'd2) zero_run = zero_run + 2'd1;
        end else if (it.data_byte == kfg_pkg::BYTE_ONE && zero_run >= 2'd2) begin
          phase    = kfg_pkg::PH_HEADER;
          zero_run = '0;
        end else begin
          zero_run = '0;
        end
      end
      default: ;
    endcase
    if (it.last_byte) begin
      if (phase != kfg_pkg::PH_DONE) scan_key = seen_sps && seen_pps;
      gap   = (prev_seq + 32'd1) != hdr_seq;
      r.gap = gap;
      r.key = 1'b0;
      if (byte_cnt == '0 || byte_cnt != hdr_len) begin
        r.action = kfg_pkg::ACT_LEN_ERR;
      end else begin
        case (hdr_fmt)
          kfg_pkg::FMT_MJPEG: begin
            dec_ready = 1'b0;
            r.action  = kfg_pkg::ACT_OTHER_FMT;
          end
          kfg_pkg::FMT_VP8: begin
            wait_kf   = wait_kf || gap;
            dec_ready = 1'b0;
            r.action  = kfg_pkg::ACT_OTHER_FMT;
          end
          kfg_pkg::FMT_H264: begin
            wait_kf = wait_kf || gap;
            if (strm_w != hdr_w || strm_h != hdr_h) begin
              dec_ready = 1'b0;
              strm_w    = hdr_w;
              strm_h    = hdr_h;
            end
            if (!dec_ready) begin
              dec_ready = 1'b1;
              wait_kf   = 1'b1;
            end
            r.key    = scan_key;
            r.action = kfg_pkg::ACT_DECODE;
            if (wait_kf) begin
              if (scan_key) wait_kf = 1'b0;
              else r.action = kfg_pkg::ACT_DROP;
            end
          end
          default: r.action = kfg_pkg::ACT_UNKNOWN;
        endcase
      end
      prev_seq  = hdr_seq;
      r.waiting = wait_kf;
      verdict_q.push_back(r);
      scan_clear();
    end
  endtask

  // Predicts on every accepted input transaction and checks every output transaction.
  always @(posedge clk) begin
    if (rst) begin
      prev_seq  = '1;
      strm_w    = '0;
      strm_h    = '0;
      dec_ready = 1'b0;
      wait_kf   = 1'b1;
      hdr_fmt   = kfg_pkg::FMT_MJPEG;
      hdr_w     = '0;
      hdr_h     = '0;
      hdr_seq   = '0;
      hdr_len   = '0;
      scan_clear();
    end else begin
      if (s_valid && s_ready) begin
        seen_item.data_byte      = s_data[7:0];
        seen_item.frame_width    = s_data[23:8];
        seen_item.frame_height   = s_data[39:24];
        seen_item.frame_sequence = s_data[71:40];
        seen_item.declared_bytes = s_data[103:72];
        seen_item.first_byte     = s_user[0];
        seen_item.frame_format   = kfg_pkg::fmt_t'(s_user[2:1]);
        seen_item.last_byte      = s_last;
        fold_frame_byte(seen_item);
      end
      if (m_valid && m_ready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("verdict with none pending", '0, 32'(m_data));
        end else begin
          kfg_pkg::result_t want;
          want = verdict_q.pop_front();
          if (m_data[2:0] !== want.action)
            report_mismatch("frame_action", 32'(want.action), 32'(m_data[2:0]));
          if (m_data[3] !== want.gap)
            report_mismatch("sequence_gap", 32'(want.gap), 32'(m_data[3]));
          if (m_data[4] !== want.key)
            report_mismatch("keyframe_seen", 32'(want.key), 32'(m_data[4]));
          if (m_data[5] !== want.waiting)
            report_mismatch("still_waiting", 32'(want.waiting), 32'(m_data[5]));
        end
      end
    end
  end

  // Receiver: a long hold when asked for, otherwise the current stall style.
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_tick % 64 == 0) rx_pat <= 8'($urandom_range(1, 255));
    else rx_pat <= {rx_pat[0], rx_pat[7:1]};
    if (hold_left != 0) begin
      m_ready   <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_reqs != hold_done) begin
      m_ready   <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= hold_done + 1;
    end else begin
      case (rx_mode)
        RX_ALWAYS: m_ready <= 1'b1;
        RX_RANDOM: m_ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: m_ready <= ($urandom_range(0, 4) == 0);
        default:   m_ready <= rx_pat[0];
      endcase
    end
  end

  task automatic send_byte(input kfg_pkg::in_item_t it);
    int gap_len;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (tx_mode == TX_BURSTY) begin
        gap_len = $urandom_range(1, 6);
        s_valid <= 1'b0;
        repeat (gap_len) @(posedge clk);
      end
    end
    burst_left--;
    s_valid <= 1'b1;
    s_data  <= {it.declared_bytes, it.frame_sequence, it.frame_height, it.frame_width,
                it.data_byte};
    s_user  <= {it.frame_format, it.first_byte};
    s_last  <= it.last_byte;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Sends frame_bytes as one frame; bytes not flagged as first carry junk header fields.
  task automatic send_frame(input kfg_pkg::fmt_t fmt, input logic [15:0] w,
                            input logic [15:0] h, input logic [31:0] seq,
                            input logic [31:0] decl, input bit with_first,
                            input bit with_last);
    kfg_pkg::in_item_t it;
    for (int i = 0; i < frame_bytes.size(); i++) begin
      it.data_byte  = frame_bytes[i];
      it.first_byte = with_first && (i == 0);
      it.last_byte  = with_last && (i == frame_bytes.size() - 1);
      if (it.first_byte) begin
        it.frame_format   = fmt;
        it.frame_width    = w;
        it.frame_height   = h;
        it.frame_sequence = seq;
        it.declared_bytes = decl;
      end else begin
        it.frame_format   = kfg_pkg::fmt_t'($urandom_range(0, 3));
        it.frame_width    = 16'($urandom);
        it.frame_height   = 16'($urandom);
        it.frame_sequence = $urandom;
        it.declared_bytes = $urandom;
      end
      send_byte(it);
    end
  endtask

  task automatic pause_until_drained();
    s_valid <= 1'b0;
    @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic push_nal(input logic [4:0] nal);
    logic [2:0] top;
    top = 3'($urandom_range(0, 7));
    if ($urandom_range(0, 3) == 0) frame_bytes.push_back(kfg_pkg::BYTE_ZERO);
    frame_bytes.push_back(kfg_pkg::BYTE_ZERO);
    frame_bytes.push_back(kfg_pkg::BYTE_ZERO);
    frame_bytes.push_back(kfg_pkg::BYTE_ONE);
    frame_bytes.push_back({top, nal});
  endtask

  task automatic build_h264_payload();
    logic [4:0] nal;
    frame_bytes.delete();
    // Parameter sets ahead of a picture, the usual shape of a keyframe.
    if ($urandom_range(0, 2) == 0) begin
      push_nal(kfg_pkg::NAL_SPS);
      repeat ($urandom_range(0, 2)) frame_bytes.push_back(8'($urandom_range(2, 255)));
      push_nal(kfg_pkg::NAL_PPS);
      push_nal(($urandom_range(0, 1) == 0) ? kfg_pkg::NAL_IDR : NAL_SLICE);
    end
    repeat ($urandom_range(0, 4)) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          case ($urandom_range(0, 5))
            0:       nal = kfg_pkg::NAL_UNSPEC;
            1:       nal = kfg_pkg::NAL_IDR;
            2:       nal = kfg_pkg::NAL_SPS;
            3:       nal = kfg_pkg::NAL_PPS;
            4:       nal = kfg_pkg::NAL_AUD;
            default: nal = 5'($urandom_range(0, 31));
          endcase
          push_nal(nal);
        end
        5, 6: repeat ($urandom_range(1, 4)) frame_bytes.push_back(8'($urandom_range(0, 255)));
        7:    repeat ($urandom_range(1, 3)) frame_bytes.push_back(8'($urandom_range(0, 1)));
        8: begin
          frame_bytes.push_back(kfg_pkg::BYTE_ZERO);
          frame_bytes.push_back(kfg_pkg::BYTE_ZERO);
        end
        default: begin
          // A start code that may end the frame before its NAL header.
          frame_bytes.push_back(kfg_pkg::BYTE_ZERO);
          frame_bytes.push_back(kfg_pkg::BYTE_ZERO);
          frame_bytes.push_back(kfg_pkg::BYTE_ONE);
        end
      endcase
    end
    if (frame_bytes.size() == 0) frame_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic test_directed();
    // Headerless byte straight after reset runs under the all-zero header.
    frame_bytes = '{8'h5a};
    send_frame(kfg_pkg::FMT_H264, 16'h1234, 16'h5678, 32'd0, 32'd0, 1'b0, 1'b1);
    // Single byte frame of unknown format at the widest frame width and height.
    frame_bytes = '{8'hff};
    send_frame(kfg_pkg::FMT_OTHER, 16'hffff, 16'hffff, 32'd1, 32'd1, 1'b1, 1'b1);
    frame_bytes = '{8'h00, 8'h00, 8'h01, 8'h65};
    send_frame(kfg_pkg::FMT_H264, 16'hffff, 16'hffff, 32'd2, 32'd4, 1'b1, 1'b1);
    // Picture parameters without sequence parameters end the scan.
    frame_bytes = '{8'h00, 8'h00, 8'h01, 8'he8};
    send_frame(kfg_pkg::FMT_H264, 16'hffff, 16'hffff, 32'd3, 32'd4, 1'b1, 1'b1);
    // Sequence gap with a four byte start code and a plain slice.
    frame_bytes = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h41};
    send_frame(kfg_pkg::FMT_H264, 16'hffff, 16'hffff, 32'd10, 32'd5, 1'b1, 1'b1);
    frame_bytes = '{8'h00, 8'h00, 8'h01, 8'h67, 8'h00, 8'h00, 8'h01, 8'h68};
    send_frame(kfg_pkg::FMT_H264, 16'hffff, 16'hffff, 32'd11, 32'd8, 1'b1, 1'b1);
    // Size change with an access unit delimiter.
    frame_bytes = '{8'h00, 8'h00, 8'h01, 8'h09};
    send_frame(kfg_pkg::FMT_H264, 16'h0000, 16'h0000, 32'd12, 32'd4, 1'b1, 1'b1);
    frame_bytes = '{8'h00};
    send_frame(kfg_pkg::FMT_VP8, 16'h0000, 16'h0000, 32'd14, 32'd1, 1'b1, 1'b1);
    send_frame(kfg_pkg::FMT_MJPEG, 16'h0000, 16'h0000, 32'd15, 32'd1, 1'b1, 1'b1);
    frame_bytes = '{8'h01};
    send_frame(kfg_pkg::FMT_H264, 16'h0000, 16'h0000, 32'd16, 32'd0, 1'b1, 1'b1);
    send_frame(kfg_pkg::FMT_H264, 16'h0000, 16'h0000, 32'd17, 32'hffffffff, 1'b1, 1'b1);
    // A first byte in mid frame abandons the frame in progress.
    frame_bytes = '{8'h00, 8'h00};
    send_frame(kfg_pkg::FMT_H264, 16'h0000, 16'h0000, 32'd20, 32'd9, 1'b1, 1'b0);
    frame_bytes = '{8'h80};
    send_frame(kfg_pkg::FMT_H264, 16'h0000, 16'h0000, 32'd18, 32'd1, 1'b1, 1'b1);
    // Headerless byte after a last byte reuses the latched header.
    frame_bytes = '{8'h00};
    send_frame(kfg_pkg::FMT_H264, 16'h0000, 16'h0000, 32'd0, 32'd0, 1'b0, 1'b1);
    stim_seq = 32'd18;
    stim_w   = 16'd0;
    stim_h   = 16'd0;
  endtask

  // Holds the receiver off while the sender keeps offering short frames.
  task automatic test_backpressure();
    rx_mode = RX_ALWAYS;
    tx_mode = TX_DENSE;
    hold_reqs++;
    @(posedge clk);
    while (m_ready) @(posedge clk);
    repeat (40) begin
      frame_bytes.delete();
      frame_bytes.push_back(8'($urandom_range(0, 255)));
      stim_seq = stim_seq + 32'd1;
      send_frame(kfg_pkg::fmt_t'($urandom_range(0, 3)), stim_w, stim_h, stim_seq, 32'd1,
                 1'b1, 1'b1);
    end
    pause_until_drained();
  endtask

  task automatic test_random_frames();
    kfg_pkg::fmt_t fmt;
    logic [31:0]   decl;
    int            frames;
    int            target;
    frames = 0;
    target = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < target) begin
      if (frames % 20 == 0) begin
        rx_mode = $urandom_range(0, 3);
        tx_mode = $urandom_range(0, 1);
      end
      if (frames % 37 == 36) pause_until_drained();
      fmt = ($urandom_range(0, 9) < 7) ? kfg_pkg::FMT_H264
                                       : kfg_pkg::fmt_t'($urandom_range(0, 3));
      if (fmt == kfg_pkg::FMT_H264) begin
        build_h264_payload();
      end else begin
        frame_bytes.delete();
        repeat ($urandom_range(1, 8)) frame_bytes.push_back(8'($urandom_range(0, 255)));
      end
      case ($urandom_range(0, 19))
        0: begin
          stim_w = 16'($urandom);
          stim_h = 16'($urandom);
        end
        1: begin
          stim_w = ($urandom_range(0, 1) == 0) ? 16'd1280 : 16'd320;
          stim_h = ($urandom_range(0, 1) == 0) ? 16'd720 : 16'd240;
        end
        default: ;
      endcase
      case ($urandom_range(0, 19))
        0:       stim_seq = $urandom;
        1:       stim_seq = stim_seq + 32'd2;
        2:       ;
        default: stim_seq = stim_seq + 32'd1;
      endcase
      decl = 32'(frame_bytes.size());
      case ($urandom_range(0, 19))
        0:       decl = decl + 32'd1;
        1:       decl = decl - 32'd1;
        2:       decl = '0;
        3:       decl = '1;
        4:       decl = $urandom;
        default: ;
      endcase
      send_frame(fmt, stim_w, stim_h, stim_seq, decl,
                 $urandom_range(0, 24) != 0, $urandom_range(0, 24) != 0);
      frames++;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    pause_until_drained();
    test_backpressure();
    test_random_frames();
    s_valid <= 1'b0;
    @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/kfg_pkg.sv
hdl/kfg_scan.sv
hdl/kfg_gate.sv
hdl/video_frame_keyframe_gate.sv
tb/sv/tb_video_frame_keyframe_gate.sv
